// ===== rtl/core/itp_pkg.sv =====
// Shared types, character constants and operator helpers for the infix to postfix converter.
// Used by itp_stack and infix_to_postfix_converter_unit; no dependencies.
package itp_pkg;

    // Default stack depth, handed to the top level parameter.
    localparam int DEF_STACK_DEPTH = 32;

    // Stored operator codes. A code of zero also marks a symbol that is no operator.
    typedef logic [2:0] op_code_t;
    localparam op_code_t CODE_OPEN = 3'd0;
    localparam op_code_t CODE_ADD  = 3'd1;
    localparam op_code_t CODE_SUB  = 3'd2;
    localparam op_code_t CODE_MUL  = 3'd3;
    localparam op_code_t CODE_DIV  = 3'd4;
    localparam op_code_t CODE_POW  = 3'd5;

    // ASCII characters that the converter treats specially.
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;

    // Error codes carried on the output word.
    typedef logic [1:0] err_t;
    localparam err_t ERR_NONE     = 2'd0;
    localparam err_t ERR_OVERFLOW = 2'd1;
    localparam err_t ERR_CLOSE    = 2'd2;
    localparam err_t ERR_OPEN     = 2'd3;

    typedef logic [1:0] prec_t;

    // Commands from the sequencer to the stack.
    typedef struct packed {
        logic     push;     // write at the top and grow
        logic     pop;      // shrink by one
        logic     replace;  // overwrite the current top entry
        logic     rd_en;    // read the top entry as it stands after this cycle
        op_code_t wr_code;
    } stack_cmd_t;

    // Status from the stack back to the sequencer.
    typedef struct packed {
        logic     empty;
        logic     full;
        logic     single;
        op_code_t top;      // registered read data
    } stack_status_t;

    // Precedence of a stored code; the open parenthesis ranks below every operator.
    function automatic prec_t op_prec(input op_code_t code);
        prec_t p;
        case (code)
            CODE_ADD, CODE_SUB: p = 2'd1;
            CODE_MUL, CODE_DIV: p = 2'd2;
            CODE_POW:           p = 2'd3;
            default:            p = 2'd0;
        endcase
        return p;
    endfunction

    // Character emitted for a stored operator code.
    function automatic logic [7:0] op_char(input op_code_t code);
        logic [7:0] c;
        case (code)
            CODE_OPEN: c = CH_OPEN;
            CODE_ADD:  c = CH_ADD;
            CODE_SUB:  c = CH_SUB;
            CODE_MUL:  c = CH_MUL;
            CODE_DIV:  c = CH_DIV;
            CODE_POW:  c = CH_POW;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    // Operator code of an input symbol, or CODE_OPEN when it is no operator.
    function automatic op_code_t sym_to_code(input logic [7:0] sym);
        op_code_t code;
        case (sym)
            CH_ADD:  code = CODE_ADD;
            CH_SUB:  code = CODE_SUB;
            CH_MUL:  code = CODE_MUL;
            CH_DIV:  code = CODE_DIV;
            CH_POW:  code = CODE_POW;
            default: code = CODE_OPEN;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/itp_in_if.sv =====
// Input channel of the converter: one infix character per word.
// No dependencies.
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink (input valid, input symbol, input last, output ready);
endinterface

// ===== rtl/core/itp_out_if.sv =====
// Output channel of the converter: one postfix character or status word per word.
// No dependencies.
interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic [1:0] error;
    logic       end_of_expression;

    modport source (output valid, output out_symbol, output has_symbol, output error,
                    output end_of_expression, input ready);
    modport sink (input valid, input out_symbol, input has_symbol, input error,
                  input end_of_expression, output ready);
endinterface

// ===== rtl/core/itp_stack.sv =====
// Operator stack: a synchronous memory with registered read data and its fill count.
// Depends on itp_pkg.
module itp_stack #(
    parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  itp_pkg::stack_cmd_t    cmd,
    output itp_pkg::stack_status_t status
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    count_m1;
    logic [CNT_W-1:0]    count_next_m1;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    itp_pkg::op_code_t   rd_data_reg;
    itp_pkg::op_code_t   mem [STACK_DEPTH];

    // Fill count update and the addresses derived from it.
    always_comb
    begin
        count_m1 = count_reg - CNT_W'(1);
        count_next = count_reg;
        if (cmd.push)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.pop)
            count_next = count_m1;
        count_next_m1 = count_next - CNT_W'(1);
        wr_en   = cmd.push | cmd.replace;
        wr_addr = cmd.push ? count_reg[ADDR_W-1:0] : count_m1[ADDR_W-1:0];
        rd_addr = count_next_m1[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Stack memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= cmd.wr_code;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign status.empty  = (count_reg == '0);
    assign status.full   = (count_reg == CNT_W'(STACK_DEPTH));
    assign status.single = (count_reg == CNT_W'(1));
    assign status.top    = rd_data_reg;

    // The sequencer must never push onto a full stack or take from an empty one.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !status.full)
        else $error("push onto a full stack");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop || cmd.replace) |-> !status.empty)
        else $error("pop or replace on an empty stack");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

endmodule

// ===== rtl/core/infix_to_postfix_converter_unit.sv =====
// Infix to postfix converter (shunting yard) built around an operator stack memory.
// Depends on itp_pkg, itp_in_if, itp_out_if and itp_stack.
//
// The unit takes one infix character per input word and sends postfix characters,
// error words and a closing end word on the output channel, one word per output
// register load. It works on one character at a time: a character is accepted in one
// cycle and handled from the next. An operand, an open parenthesis (pushed or dropped
// on overflow) or an operator that meets an empty stack is handled directly. An
// operator that meets a non-empty stack reads the top, pops and emits each entry that
// binds at least as tightly and then pushes or sends an overflow word; if its pops
// empty the stack, the push replaces the last entry in the same cycle as its pop. A
// close parenthesis reads the top and pops each entry, emitting the operators and
// dropping the matching open parenthesis; without a match it sends an error word.
// The read of the next entry overlaps the emit of the current one through the
// registered read of the stack memory. A character marked last then flushes the
// remaining entries and sends the end word.
// Cycles in which the output register is full and not taken stall the sequence.
// The stack memory needs no clearing after reset.
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    itp_in_if.sink           sym_in,
    itp_out_if.source        pfx_out
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_OPCHK = 3'd2;
    localparam logic [2:0] S_CLOSE = 3'd3;
    localparam logic [2:0] S_ERR2  = 3'd4;
    localparam logic [2:0] S_LAST  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;
    localparam logic [2:0] S_END   = 3'd7;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [7:0]             sym_reg;
    logic [7:0]             sym_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   open_flag_reg;
    logic                   open_flag_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_sym_reg;
    logic [7:0]             out_sym_next;
    logic                   out_has_reg;
    logic                   out_has_next;
    itp_pkg::err_t          out_err_reg;
    itp_pkg::err_t          out_err_next;
    logic                   out_end_reg;
    logic                   out_end_next;

    itp_pkg::stack_cmd_t    cmd;
    itp_pkg::stack_status_t st;

    logic                   slot_free;
    logic                   emit;
    logic [7:0]             emit_sym;
    logic                   emit_has;
    itp_pkg::err_t          emit_err;
    logic                   emit_end;
    itp_pkg::op_code_t      in_code;
    logic                   is_open;
    logic                   is_close;
    logic                   is_op;
    logic                   top_wins;
    logic [2:0]             after_item;

    itp_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (st)
    );

    // Character classification of the held input word.
    always_comb
    begin
        in_code    = itp_pkg::sym_to_code(sym_reg);
        is_open    = (sym_reg == itp_pkg::CH_OPEN);
        is_close   = (sym_reg == itp_pkg::CH_CLOSE);
        is_op      = (in_code != itp_pkg::CODE_OPEN);
        top_wins   = (itp_pkg::op_prec(st.top) >= itp_pkg::op_prec(in_code));
        after_item = last_reg ? S_LAST : S_IDLE;
        slot_free  = !out_valid_reg || pfx_out.ready;
    end

    // Sequencer: reads the stack top, pops, pushes and loads the output register.
    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        open_flag_next = open_flag_reg;
        cmd            = '0;
        emit           = 1'b0;
        emit_sym       = 8'h00;
        emit_has       = 1'b0;
        emit_err       = itp_pkg::ERR_NONE;
        emit_end       = 1'b0;
        sym_in.ready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                sym_in.ready = 1'b1;
                if (sym_in.valid)
                begin
                    sym_next   = sym_in.symbol;
                    last_next  = sym_in.last;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                if (is_open)
                begin
                    if (!st.full)
                    begin
                        cmd.push    = 1'b1;
                        cmd.wr_code = itp_pkg::CODE_OPEN;
                        state_next  = after_item;
                    end
                    else if (slot_free)
                    begin
                        emit       = 1'b1;
                        emit_err   = itp_pkg::ERR_OVERFLOW;
                        state_next = after_item;
                    end
                end
                else if (is_op)
                begin
                    if (st.empty)
                    begin
                        cmd.push    = 1'b1;
                        cmd.wr_code = in_code;
                        state_next  = after_item;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_OPCHK;
                    end
                end
                else if (is_close)
                begin
                    if (st.empty)
                        state_next = S_ERR2;
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_CLOSE;
                    end
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_sym   = sym_reg;
                    emit_has   = 1'b1;
                    state_next = after_item;
                end
            end

            // Pop while the top binds at least as tightly, then push the operator (or send an overflow word when full).
            S_OPCHK:
            begin
                if (top_wins)
                begin
                    if (slot_free)
                    begin
                        emit     = 1'b1;
                        emit_sym = itp_pkg::op_char(st.top);
                        emit_has = 1'b1;
                        if (st.single)
                        begin
                            cmd.replace = 1'b1;
                            cmd.wr_code = in_code;
                            state_next  = after_item;
                        end
                        else
                        begin
                            cmd.pop   = 1'b1;
                            cmd.rd_en = 1'b1;
                        end
                    end
                end
                else if (!st.full)
                begin
                    cmd.push    = 1'b1;
                    cmd.wr_code = in_code;
                    state_next  = after_item;
                end
                else if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_err   = itp_pkg::ERR_OVERFLOW;
                    state_next = after_item;
                end
            end

            // Pop down to the matching open parenthesis, which is dropped; without one, an error word follows.
            S_CLOSE:
            begin
                if (st.top == itp_pkg::CODE_OPEN)
                begin
                    cmd.pop    = 1'b1;
                    state_next = after_item;
                end
                else if (slot_free)
                begin
                    emit     = 1'b1;
                    emit_sym = itp_pkg::op_char(st.top);
                    emit_has = 1'b1;
                    cmd.pop  = 1'b1;
                    if (st.single)
                        state_next = S_ERR2;
                    else
                        cmd.rd_en = 1'b1;
                end
            end

            S_ERR2:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_err   = itp_pkg::ERR_CLOSE;
                    state_next = after_item;
                end
            end

            S_LAST:
            begin
                open_flag_next = 1'b0;
                if (st.empty)
                    state_next = S_END;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_FLUSH;
                end
            end

            // Final flush: operators are emitted, open parentheses only flagged.
            S_FLUSH:
            begin
                if (st.top == itp_pkg::CODE_OPEN || slot_free)
                begin
                    if (st.top == itp_pkg::CODE_OPEN)
                        open_flag_next = 1'b1;
                    else
                    begin
                        emit     = 1'b1;
                        emit_sym = itp_pkg::op_char(st.top);
                        emit_has = 1'b1;
                    end
                    cmd.pop = 1'b1;
                    if (st.single)
                        state_next = S_END;
                    else
                        cmd.rd_en = 1'b1;
                end
            end

            S_END:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_err   = open_flag_reg ? itp_pkg::ERR_OPEN : itp_pkg::ERR_NONE;
                    emit_end   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register loads.
    always_comb
    begin
        out_valid_next = out_valid_reg && !pfx_out.ready;
        out_sym_next   = out_sym_reg;
        out_has_next   = out_has_reg;
        out_err_next   = out_err_reg;
        out_end_next   = out_end_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_sym_next   = emit_sym;
            out_has_next   = emit_has;
            out_err_next   = emit_err;
            out_end_next   = emit_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            open_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_flag_reg <= open_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg     <= sym_next;
        last_reg    <= last_next;
        out_sym_reg <= out_sym_next;
        out_has_reg <= out_has_next;
        out_err_reg <= out_err_next;
        out_end_reg <= out_end_next;
    end

    assign pfx_out.valid             = out_valid_reg;
    assign pfx_out.out_symbol        = out_sym_reg;
    assign pfx_out.has_symbol        = out_has_reg;
    assign pfx_out.error             = out_err_reg;
    assign pfx_out.end_of_expression = out_end_reg;

    // A word without a character carries a zero symbol.
    a_empty_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_has_reg) |-> (out_sym_reg == 8'h00))
        else $error("status word with a nonzero symbol");

    // Character words never carry an error or the end mark.
    a_char_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_has_reg) |->
            (out_err_reg == itp_pkg::ERR_NONE) && !out_end_reg)
        else $error("character word with error or end mark");

    // The output register is never overwritten while it still holds an untaken word.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pfx_out.ready) |-> !emit)
        else $error("output word overwritten before it was taken");

endmodule
